FILE: hdl/byte_ring_fifo_burst_defines.svh
// Assertion macros shared by the byte ring FIFO modules.
`ifndef BYTE_RING_FIFO_BURST_DEFINES_SVH
`define BYTE_RING_FIFO_BURST_DEFINES_SVH

// Check a property on every rising clock edge once out of reset.
`define BRFB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition leads to another in the next cycle.
`define BRFB_ASSERT_NEXT(label, pre, post, msg) \
   `BRFB_ASSERT(label, (pre) |=> (post), msg)

`endif

FILE: hdl/brfb_pkg.sv
// Shared widths, codes and control structs of the byte ring FIFO.
package brfb_pkg;

   localparam int CMD_W     = 2;
   localparam int LEN_W     = 7;
   localparam int PUT_BITS  = 64;
   localparam int BYTE_W    = 8;
   localparam int ST_W      = 3;
   localparam int CAP_W     = 10;
   localparam int CSR_IDX_W = 2;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_BAD_LEN  = 3'd1;
   localparam logic [ST_W-1:0] ST_NO_ROOM  = 3'd2;
   localparam logic [ST_W-1:0] ST_OVER_MAX = 3'd3;
   localparam logic [ST_W-1:0] ST_TOO_FEW  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_READ = 2'd1;

   // Controller to datapath.
   typedef struct packed {
      logic take_item;
      logic put_write;
      logic rd_issue;
      logic load_byte;
      logic load_status;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic chk_ok;
      logic rem_last;
      logic out_free;
   } dp_stat_type;

endpackage

FILE: hdl/brfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/brfb_dpath.sv
// Datapath: ring indices, counts, byte store and result register.
`include "byte_ring_fifo_burst_defines.svh"

module brfb_dpath import brfb_pkg::*; #(
   parameter int STORE_DEPTH = 1024,
   parameter int PUT_WIDTH   = 8,
   parameter int READ_MAX    = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_cmd_type          cmd,
   output dp_stat_type          stat,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [LEN_W-1:0]     req_length,
   input  logic [PUT_BITS-1:0]  req_put_bytes,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAP_W-1:0]     csr_wdata,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [ST_W-1:0]      rsp_status,
   output logic [BYTE_W-1:0]    rsp_data_byte,
   output logic                 rsp_last,
   output logic [CAP_W-1:0]     rsp_held_count,
   output logic [CAP_W-1:0]     rsp_free_count
);

   localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;
   localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(STORE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CAP_RST = (CNT_W'(1023) > CAP_MAX) ? CAP_MAX : CNT_W'(1023);
   localparam logic [LEN_W-1:0] PUT_MAX = LEN_W'(PUT_WIDTH);
   localparam logic [LEN_W-1:0] LIM_MAX = LEN_W'(READ_MAX);
   localparam logic [LEN_W-1:0] LIM_RST = (LEN_W'(64) > LIM_MAX) ? LIM_MAX : LEN_W'(64);

   logic [CNT_W-1:0]    cap_ff, cap_in;
   logic [LEN_W-1:0]    lim_ff, lim_in;
   logic [AW-1:0]       rd_idx_ff, rd_idx_in;
   logic [AW-1:0]       wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [LEN_W-1:0]    rem_ff, rem_in;
   logic [PUT_BITS-1:0] bytes_ff, bytes_in;
   logic [ST_W-1:0]     status_ff, status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [CAP_W-1:0]    rsp_held_ff, rsp_held_in;
   logic [CAP_W-1:0]    rsp_free_ff, rsp_free_in;

   logic [CNT_W-1:0]    ring;
   logic [CNT_W-1:0]    free_cnt;
   logic [CNT_W-1:0]    len_ext;
   logic [CNT_W-1:0]    cap_wr;
   logic [LEN_W-1:0]    lim_wr;
   logic [ST_W-1:0]     chk_status;
   logic [AW-1:0]       rd_adv, wr_next, pos_next;
   logic [BYTE_W-1:0]   ram_rdata;

   // Add and wrap once; the sum stays below twice the ring size.
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                              input logic [CNT_W-1:0] b,
                                              input logic [CNT_W-1:0] r);
      logic [CNT_W-1:0] s;
      s = CNT_W'(a) + b;
      if (s >= r) begin
         s = s - r;
      end
      return s[AW-1:0];
   endfunction

   assign ring     = cap_ff + CNT_W'(1);
   assign free_cnt = cap_ff - held_ff;
   assign len_ext  = CNT_W'(req_length);
   assign cap_wr   = CNT_W'(csr_wdata);
   assign lim_wr   = csr_wdata[LEN_W-1:0];
   assign rd_adv   = wrap_add(rd_idx_ff, len_ext, ring);
   assign wr_next  = wrap_add(wr_idx_ff, CNT_W'(1), ring);
   assign pos_next = wrap_add(pos_ff, CNT_W'(1), ring);

   always_comb begin
      chk_status = ST_OK;
      case (req_cmd)
         CMD_PUT: begin
            if (req_length == '0 || req_length > PUT_MAX) begin
               chk_status = ST_BAD_LEN;
            end else if (len_ext > free_cnt) begin
               chk_status = ST_NO_ROOM;
            end
         end
         CMD_GET, CMD_PEEK: begin
            if (req_length == '0) begin
               chk_status = ST_BAD_LEN;
            end else if (req_length > lim_ff) begin
               chk_status = ST_OVER_MAX;
            end else if (len_ext > held_ff) begin
               chk_status = ST_TOO_FEW;
            end
         end
         default: chk_status = ST_OK;
      endcase
   end

   always_comb begin
      cap_in    = cap_ff;
      lim_in    = lim_ff;
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      held_in   = held_ff;
      pos_in    = pos_ff;
      rem_in    = rem_ff;
      bytes_in  = bytes_ff;
      status_in = status_ff;
      if (cmd.take_item) begin
         bytes_in  = req_put_bytes;
         rem_in    = req_length;
         pos_in    = rd_idx_ff;
         status_in = chk_status;
         if (req_cmd == CMD_CLEAR) begin
            rd_idx_in = '0;
            wr_idx_in = '0;
            held_in   = '0;
         end else if (chk_status == ST_OK) begin
            if (req_cmd == CMD_PUT) begin
               held_in = held_ff + len_ext;
            end else if (req_cmd == CMD_GET) begin
               // advance now; the bytes are read from the saved start
               rd_idx_in = rd_adv;
               held_in   = held_ff - len_ext;
            end
         end
      end
      if (cmd.put_write) begin
         wr_idx_in = wr_next;
         bytes_in  = bytes_ff >> BYTE_W;
         rem_in    = rem_ff - LEN_W'(1);
      end
      if (cmd.rd_issue) begin
         pos_in = pos_next;
      end
      if (cmd.load_byte) begin
         rem_in = rem_ff - LEN_W'(1);
      end
      if (csr_write_en) begin
         case (csr_index)
            CSR_CAPACITY: begin
               cap_in    = (cap_wr > CAP_MAX) ? CAP_MAX : cap_wr;
               rd_idx_in = '0;
               wr_idx_in = '0;
               held_in   = '0;
            end
            CSR_MAX_READ: lim_in = (lim_wr > LIM_MAX) ? LIM_MAX : lim_wr;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_held_in   = rsp_held_ff;
      rsp_free_in   = rsp_free_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_byte) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_data_in   = ram_rdata;
         rsp_last_in   = (rem_ff == LEN_W'(1));
         rsp_held_in   = held_ff[CAP_W-1:0];
         rsp_free_in   = free_cnt[CAP_W-1:0];
      end
      if (cmd.load_status) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_data_in   = '0;
         rsp_last_in   = 1'b1;
         rsp_held_in   = held_ff[CAP_W-1:0];
         rsp_free_in   = free_cnt[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RST;
         lim_ff       <= LIM_RST;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         held_ff      <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         lim_ff       <= lim_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         held_ff      <= held_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      bytes_ff      <= bytes_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_held_ff   <= rsp_held_in;
      rsp_free_ff   <= rsp_free_in;
   end

   brfb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (cmd.put_write),
      .waddr (wr_idx_ff),
      .wdata (bytes_ff[BYTE_W-1:0]),
      .re    (cmd.rd_issue),
      .raddr (pos_ff),
      .rdata (ram_rdata)
   );

   assign stat.chk_ok   = (chk_status == ST_OK);
   assign stat.rem_last = (rem_ff == LEN_W'(1));
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_byte  = rsp_data_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_held_count = rsp_held_ff;
   assign rsp_free_count = rsp_free_ff;

   `BRFB_ASSERT(a_held_in_cap, held_ff <= cap_ff, "held count above capacity")
   `BRFB_ASSERT(a_rd_in_ring, CNT_W'(rd_idx_ff) < ring, "read index outside ring")
   `BRFB_ASSERT(a_wr_in_ring, CNT_W'(wr_idx_ff) < ring, "write index outside ring")

endmodule

FILE: hdl/brfb_ctrl.sv
// Controller: sequences puts, byte reads and status results.
`include "byte_ring_fifo_burst_defines.svh"

module brfb_ctrl import brfb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_cmd,
   output logic             req_stall,
   input  dp_stat_type      stat,
   output ctl_cmd_type      cmd
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_PUT      = 5'b00010,
      S_RD_ISSUE = 5'b00100,
      S_RD_LOAD  = 5'b01000,
      S_RESULT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               if (req_cmd == CMD_CLEAR || !stat.chk_ok) begin
                  state_in = S_RESULT;
               end else if (req_cmd == CMD_PUT) begin
                  state_in = S_PUT;
               end else begin
                  state_in = S_RD_ISSUE;
               end
            end
         end
         S_PUT: begin
            cmd.put_write = 1'b1;
            if (stat.rem_last) begin
               state_in = S_RESULT;
            end
         end
         S_RD_ISSUE: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_RD_LOAD;
         end
         S_RD_LOAD: begin
            // hold the read byte until the result register frees up
            if (stat.out_free) begin
               cmd.load_byte = 1'b1;
               state_in      = stat.rem_last ? S_IDLE : S_RD_ISSUE;
            end
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.load_status = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   `BRFB_ASSERT_NEXT(a_issue_then_load, state_ff == S_RD_ISSUE, state_ff == S_RD_LOAD, "read issue not followed by load")
   `BRFB_ASSERT_NEXT(a_put_path, req_valid && !req_stall && req_cmd == CMD_PUT, state_ff == S_PUT || state_ff == S_RESULT, "put took wrong path")
   `BRFB_ASSERT(a_no_overwrite, (cmd.load_byte || cmd.load_status) |-> stat.out_free, "result register overwritten")

endmodule

FILE: hdl/byte_ring_fifo_burst.sv
// Top level of the circular byte FIFO with burst puts and reads.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  cmd, length, put_bytes
//   rsp      out        rsp_valid/rsp_stall  status, data_byte, last, held/free counts
//   csr      in         csr_write_en         csr_index, csr_wdata
//
// Put: one store write per byte (byte-wide write port), then a status result.
// Get/peek: each byte goes through a read issue state and then a load state
// through the registered read port of the byte store.
// Errors and clear: a single status result. req is stalled while an item is in work.
// Reset empties the ring; capacity 1023 and max read 64 (clamped to params).
// A stall on rsp holds the result register and pauses the sequencer before a result load.
module byte_ring_fifo_burst import brfb_pkg::*; #(
   parameter int STORE_DEPTH = 1024,
   parameter int PUT_WIDTH   = 8,
   parameter int READ_MAX    = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [LEN_W-1:0]     req_length,
   input  logic [PUT_BITS-1:0]  req_put_bytes,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ST_W-1:0]      rsp_status,
   output logic [BYTE_W-1:0]    rsp_data_byte,
   output logic                 rsp_last,
   output logic [CAP_W-1:0]     rsp_held_count,
   output logic [CAP_W-1:0]     rsp_free_count,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAP_W-1:0]     csr_wdata
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   brfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   brfb_dpath #(
      .STORE_DEPTH (STORE_DEPTH),
      .PUT_WIDTH   (PUT_WIDTH),
      .READ_MAX    (READ_MAX)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_cmd        (req_cmd),
      .req_length     (req_length),
      .req_put_bytes  (req_put_bytes),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_last       (rsp_last),
      .rsp_held_count (rsp_held_count),
      .rsp_free_count (rsp_free_count)
   );

endmodule

FILE: tb/sv/brfb_ring_checker.sv
// Checker for the byte ring FIFO: predicts every result item and compares it as it is taken.
module brfb_ring_checker import brfb_pkg::*; #(
   parameter int STORE_DEPTH = 1024,
   parameter int PUT_WIDTH   = 8,
   parameter int READ_MAX    = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [LEN_W-1:0]     req_length,
   input  logic [PUT_BITS-1:0]  req_put_bytes,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [ST_W-1:0]      rsp_status,
   input  logic [BYTE_W-1:0]    rsp_data_byte,
   input  logic                 rsp_last,
   input  logic [CAP_W-1:0]     rsp_held_count,
   input  logic [CAP_W-1:0]     rsp_free_count,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAP_W-1:0]     csr_wdata,
   output int                   fail_count,
   output int                   pending,
   output logic [CAP_W-1:0]     model_held,
   output logic [CAP_W-1:0]     model_free
);

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic [BYTE_W-1:0] data_byte;
      logic              is_last;
      logic [CAP_W-1:0]  held;
      logic [CAP_W-1:0]  free;
   } ring_rsp_type;

   ring_rsp_type      rsp_due_q[$];
   ring_rsp_type      due;
   logic [BYTE_W-1:0] ring_mem [STORE_DEPTH];
   int                rd_ptr;
   int                wr_ptr;
   logic [CAP_W-1:0]  cap_reg;
   logic [LEN_W-1:0]  max_reg;

   initial begin
      fail_count = 0;
      pending    = 0;
      model_held = '0;
      model_free = '0;
   end

   function automatic int ring_slots();
      int c;
      c = int'(cap_reg);
      if (c > STORE_DEPTH - 1) c = STORE_DEPTH - 1;
      return c + 1;
   endfunction

   function automatic int bytes_held();
      int r;
      r = ring_slots();
      if (rd_ptr > wr_ptr) return r + wr_ptr - rd_ptr;
      return wr_ptr - rd_ptr;
   endfunction

   function automatic int bytes_free();
      return ring_slots() - 1 - bytes_held();
   endfunction

   // Wrap by compare and subtract, as the ring does.
   function automatic int ring_advance(int p, int n);
      int r;
      int s;
      r = ring_slots();
      s = p + n;
      if (s >= r) s -= r;
      if (s >= r) s = 0;
      return s;
   endfunction

   function automatic void owe_rsp(logic [ST_W-1:0] st, logic [BYTE_W-1:0] b, logic fin);
      ring_rsp_type e;
      e.status    = st;
      e.data_byte = b;
      e.is_last   = fin;
      e.held      = CAP_W'(bytes_held());
      e.free      = CAP_W'(bytes_free());
      rsp_due_q.push_back(e);
   endfunction

   function automatic void run_command(logic [CMD_W-1:0] cmd, int len,
                                       logic [PUT_BITS-1:0] bytes);
      int lim;
      int pos;
      if (cmd == CMD_CLEAR) begin
         rd_ptr = 0;
         wr_ptr = 0;
         owe_rsp(ST_OK, '0, 1'b1);
      end else if (cmd == CMD_PUT) begin
         if (len == 0 || len > PUT_WIDTH) begin
            owe_rsp(ST_BAD_LEN, '0, 1'b1);
         end else if (len > bytes_free()) begin
            owe_rsp(ST_NO_ROOM, '0, 1'b1);
         end else begin
            for (int i = 0; i < len; i++) begin
               ring_mem[wr_ptr] = bytes[8*i +: 8];
               wr_ptr = ring_advance(wr_ptr, 1);
            end
            owe_rsp(ST_OK, '0, 1'b1);
         end
      end else begin
         lim = (int'(max_reg) > READ_MAX) ? READ_MAX : int'(max_reg);
         if (len == 0) begin
            owe_rsp(ST_BAD_LEN, '0, 1'b1);
         end else if (len > lim) begin
            owe_rsp(ST_OVER_MAX, '0, 1'b1);
         end else if (len > bytes_held()) begin
            owe_rsp(ST_TOO_FEW, '0, 1'b1);
         end else begin
            pos = rd_ptr;
            // Get reports the counts after the read position has moved.
            if (cmd == CMD_GET) rd_ptr = ring_advance(rd_ptr, len);
            for (int k = 0; k < len; k++) begin
               owe_rsp(ST_OK, ring_mem[pos], k == len - 1);
               pos = ring_advance(pos, 1);
            end
         end
      end
   endfunction

   function automatic void check_field(string name, logic [CAP_W-1:0] want,
                                       logic [CAP_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_due_q.delete();
         rd_ptr  = 0;
         wr_ptr  = 0;
         cap_reg = CAP_W'(1023);
         max_reg = LEN_W'(READ_MAX);
      end else begin
         // Compare before predicting so a transfer never meets its own item.
         if (rsp_valid && !rsp_stall) begin
            if (rsp_due_q.size() == 0) begin
               $error("result with nothing outstanding: status %0d, byte %0d",
                      rsp_status, rsp_data_byte);
               fail_count++;
            end else begin
               due = rsp_due_q.pop_front();
               check_field("status", CAP_W'(due.status), CAP_W'(rsp_status));
               check_field("data_byte", CAP_W'(due.data_byte), CAP_W'(rsp_data_byte));
               check_field("last", CAP_W'(due.is_last), CAP_W'(rsp_last));
               check_field("held_count", due.held, rsp_held_count);
               check_field("free_count", due.free, rsp_free_count);
            end
         end
         if (csr_write_en) begin
            if (csr_index == CSR_CAPACITY) begin
               cap_reg = csr_wdata;
               rd_ptr  = 0;
               wr_ptr  = 0;
            end else if (csr_index == CSR_MAX_READ) begin
               max_reg = csr_wdata[LEN_W-1:0];
            end
         end
         if (req_valid && !req_stall)
            run_command(req_cmd, int'(req_length), req_put_bytes);
      end
      pending    <= rsp_due_q.size();
      model_held <= CAP_W'(bytes_held());
      model_free <= CAP_W'(bytes_free());
   end

endmodule

FILE: tb/sv/tb_byte_ring_fifo_burst.sv
// Testbench top for the byte ring FIFO: clock, reset, stimulus, watchdog and verdict.
module tb_byte_ring_fifo_burst;
   import brfb_pkg::*;

   localparam int READ_LIMIT    = 64;
   localparam int PUT_LIMIT     = 8;
   localparam int RAND_PER_SEG  = 64;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 140;
   localparam int QUIET_LIMIT   = 5000;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_cmd       = CMD_PUT;
   logic [LEN_W-1:0]     req_length    = '0;
   logic [PUT_BITS-1:0]  req_put_bytes = '0;
   logic                 rsp_valid;
   logic                 rsp_stall     = 1'b0;
   logic [ST_W-1:0]      rsp_status;
   logic [BYTE_W-1:0]    rsp_data_byte;
   logic                 rsp_last;
   logic [CAP_W-1:0]     rsp_held_count;
   logic [CAP_W-1:0]     rsp_free_count;
   logic                 csr_write_en  = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index     = CSR_CAPACITY;
   logic [CAP_W-1:0]     csr_wdata     = '0;

   int                   fail_count;
   int                   pending;
   logic [CAP_W-1:0]     model_held;
   logic [CAP_W-1:0]     model_free;

   int send_idle_pct = 21;
   int rcv_stall_pct = 88;
   int cur_lim       = READ_LIMIT;
   int quiet_cycles  = 0;

   int seg_cap[6] = '{5, 1023, 1, 17, 200, 63};
   int seg_max[6] = '{127, 64, 1, 9, 64, 32};

   byte_ring_fifo_burst dut (.*);

   brfb_ring_checker ring_chk (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < rcv_stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Hold the item until the transfer; valid is never dropped and raised in one step.
   task automatic push_item(logic [CMD_W-1:0] cmd, int len, logic [PUT_BITS-1:0] bytes);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_length    <= LEN_W'(len);
      req_put_bytes <= bytes;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= CAP_W'(data);
      @(posedge clock);
   endtask

   task automatic set_config(int cap, int maxv);
      int m;
      m = maxv & 'h7F;
      wait_idle();
      csr_write(CSR_CAPACITY, cap);
      csr_write(CSR_MAX_READ, maxv);
      csr_write_en <= 1'b0;
      cur_lim = (m > READ_LIMIT) ? READ_LIMIT : m;
   endtask

   // Mostly well-formed puts and reads sized from the predicted fill level.
   task automatic random_item();
      int               roll;
      int               h;
      int               f;
      int               len;
      logic [CMD_W-1:0] cmd;
      h    = int'(model_held);
      f    = int'(model_free);
      roll = $urandom_range(99);
      len  = 1;
      if (roll < 45) begin
         cmd = CMD_PUT;
         if (f > 0 && $urandom_range(3) != 0)
            len = $urandom_range(1, (f < PUT_LIMIT) ? f : PUT_LIMIT);
         else
            len = $urandom_range(1, PUT_LIMIT);
      end else if (roll < 85) begin
         cmd = (roll < 70) ? CMD_GET : CMD_PEEK;
         if (h > 0 && cur_lim > 0 && $urandom_range(7) != 0)
            len = $urandom_range(1, (h < cur_lim) ? h : cur_lim);
         else
            len = $urandom_range(1, READ_LIMIT);
      end else if (roll < 90) begin
         cmd = CMD_CLEAR;
         len = $urandom_range(0, 127);
      end else begin
         cmd = CMD_W'($urandom_range(3));
         len = $urandom_range(0, 127);
      end
      push_item(cmd, len, {$urandom, $urandom});
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Default settings: errors on an empty ring, then bursts in and out.
      push_item(CMD_PEEK, 1, '0);
      push_item(CMD_GET, 0, '0);
      push_item(CMD_PUT, 0, '1);
      push_item(CMD_PUT, 9, '1);
      push_item(CMD_PUT, 127, '1);
      push_item(CMD_PUT, 8, '1);
      push_item(CMD_PUT, 8, 64'h0123_4567_89AB_CDEF);
      push_item(CMD_PUT, 1, '0);
      push_item(CMD_GET, 65, '0);
      push_item(CMD_GET, 127, '0);
      push_item(CMD_PEEK, 64, '0);
      push_item(CMD_PEEK, 17, '0);
      push_item(CMD_GET, 3, '0);
      push_item(CMD_PEEK, 0, '0);
      push_item(CMD_GET, 14, '0);
      push_item(CMD_CLEAR, 0, '0);

      // Zero capacity; max read written with upper bits set, clamps to the limit.
      set_config(0, 'h3C7);
      push_item(CMD_PUT, 1, 64'hA5);
      push_item(CMD_PEEK, 1, '0);

      // Full capacity, max read zero; spare indexes must be ignored.
      set_config(1023, 0);
      csr_write(CSR_SPARE_A, 'h3FF);
      csr_write(CSR_SPARE_B, 'h155);
      csr_write_en <= 1'b0;
      push_item(CMD_PUT, 8, 64'hFEDC_BA98_7654_3210);
      push_item(CMD_GET, 1, '0);
      push_item(CMD_PEEK, 64, '0);

      // Tiny ring: overflow, then fill exactly, then a read past max read.
      set_config(10, 1);
      push_item(CMD_PUT, 8, 64'h8877_6655_4433_2211);
      push_item(CMD_PUT, 3, 64'h00CC_BBAA);
      push_item(CMD_PUT, 2, 64'hEEDD);
      push_item(CMD_GET, 1, '0);
      push_item(CMD_GET, 2, '0);

      for (int seg = 0; seg < 6; seg++) begin
         if (seg == 2) begin
            send_idle_pct = 88;
            rcv_stall_pct = 21;
         end else if (seg == 4) begin
            send_idle_pct = 0;
            rcv_stall_pct = 0;
         end
         set_config(seg_cap[seg], seg_max[seg]);
         repeat (RAND_PER_SEG) random_item();
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
